/* hdl/rcc_pkg.sv */
// ----------------------------------------------------------------------------
// rcc_pkg: shared definitions for the RC channel conditioner
// Field widths, mapping constants and the shared divider geometry.
// ----------------------------------------------------------------------------
package rcc_pkg;

   localparam int CHAN_W     = 4;
   localparam int RAW_W      = 11;
   localparam int VALUE_W    = 9;
   localparam int DB_W       = 7;
   localparam int SAMPLE_W   = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DEFAULT_WINDOW_DEPTH = 5;
   localparam logic [DB_W-1:0] DEADBAND_RESET = 7'd2;

   // Shared divider: unsigned dividend and divisor, several quotient bits per cycle.
   localparam int DIV_N_W       = 20;
   localparam int DIV_D_W       = 11;
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = DIV_N_W / DIV_STEP_BITS;

   localparam logic [RAW_W-1:0]   MAP_LO       = 11'd172;
   localparam logic [DIV_D_W-1:0] MAP_SPAN     = 11'd1639;
   localparam logic [DIV_D_W-1:0] SLIDER_SPAN  = 11'd254;

   typedef struct packed {
      logic push;
      logic sel;
   } win_cmd_type;

endpackage

/* hdl/rcc_if.sv */
// ----------------------------------------------------------------------------
// rcc_if: item channels of the RC channel conditioner
// Valid/ready channels for raw channel samples and conditioned values.
// ----------------------------------------------------------------------------
interface rcc_req_if;
   import rcc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] channel;
   logic [RAW_W-1:0]  raw_value;

   modport source (output valid, output channel, output raw_value, input ready);
   modport sink   (input valid, input channel, input raw_value, output ready);
endinterface

interface rcc_rsp_if;
   import rcc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

/* hdl/rc_channel_conditioner_unit.sv */
// ----------------------------------------------------------------------------
// rc_channel_conditioner_unit: RC receiver channel conditioner
// Every item goes through the mapping division; sticks, switches and unused
// channels are then conditioned, sliders take a second division, and gyro
// channels sum their window one sample per cycle and divide by the fill count.
// A new item is accepted only after the previous result has been issued.
// Reset: synchronous; clears the sequencer, fill counts and the deadband to 2.
// ----------------------------------------------------------------------------
module rc_channel_conditioner_unit #(
   parameter int WINDOW_DEPTH = rcc_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   rcc_req_if.sink                         req_chan,
   rcc_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rcc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rcc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rcc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import rcc_pkg::*;

   localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);

   localparam logic signed [VALUE_W-1:0] SW_DOWN = 9'sd0;
   localparam logic signed [VALUE_W-1:0] SW_MID  = 9'sd1;
   localparam logic signed [VALUE_W-1:0] SW_UP   = 9'sd2;
   localparam logic signed [VALUE_W-1:0] SW_ON   = 9'sd1;

   typedef enum logic [3:0] {
      S_IDLE, S_MAP_GO, S_MAP_WAIT, S_COND, S_SLD_GO, S_SUM, S_AVG_GO,
      S_DIV_WAIT, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      K_STICK, K_SLIDER, K_TRI, K_DUAL, K_GYRO_X, K_GYRO_Y, K_NONE
   } kind_type;

   state_type                  state_ff, state_in;
   logic [CHAN_W-1:0]          chan_ff, chan_in;
   logic [RAW_W-1:0]           raw_ff, raw_in;
   logic signed [SAMPLE_W-1:0] v_ff, v_in;
   logic signed [VALUE_W-1:0]  res_ff, res_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic signed [SUM_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   kind_type                   kind;
   logic [DB_W-1:0]            deadband;
   logic                       div_start;
   logic                       div_done;
   logic [DIV_N_W-1:0]         div_dividend;
   logic [DIV_D_W-1:0]         div_divisor;
   logic [DIV_N_W-1:0]         div_quot;
   win_cmd_type                win_cmd;
   logic signed [SAMPLE_W-1:0] win_rd_data;
   logic [FILL_W-1:0]          win_fill;

   logic signed [RAW_W:0]      map_diff;
   logic                       map_neg;
   logic [RAW_W-1:0]           map_mag;
   logic [DIV_N_W-1:0]         map_num;
   logic signed [RAW_W-1:0]    map_q;
   logic signed [RAW_W-1:0]    map_sgn;
   logic signed [RAW_W-1:0]    map_full;
   logic signed [SAMPLE_W-1:0] map_val;
   logic [SAMPLE_W-1:0]        v_abs;
   logic signed [SAMPLE_W-1:0] c_val;
   logic signed [SAMPLE_W-1:0] t_val;
   logic signed [SAMPLE_W-1:0] neg_t;
   logic [VALUE_W-1:0]         sld_sum;
   logic [SAMPLE_W-1:0]        sld_s;
   logic [DIV_N_W-1:0]         sld_num;
   logic [SUM_W-1:0]           acc_mag;
   logic signed [VALUE_W-1:0]  avg_q;
   logic signed [VALUE_W-1:0]  tri_res;
   logic signed [VALUE_W-1:0]  dual_res;

   rcc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .deadband (deadband)
   );

   rcc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   rcc_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .IDX_W        (IDX_W),
      .FILL_W       (FILL_W)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .cmd     (win_cmd),
      .sample  (v_ff),
      .rd_idx  (idx_ff),
      .rd_data (win_rd_data),
      .fill    (win_fill)
   );

   always_comb begin
      case (chan_ff) inside
         [4'd0:4'd3]: kind = K_STICK;
         [4'd4:4'd5]: kind = K_SLIDER;
         [4'd6:4'd7]: kind = K_TRI;
         [4'd8:4'd9]: kind = K_DUAL;
         4'd10:       kind = K_GYRO_X;
         4'd11:       kind = K_GYRO_Y;
         default:     kind = K_NONE;
      endcase
   end

   // Linear map: (raw - 172) * 254 / 1639 - 127, quotient truncated toward zero.
   assign map_diff = $signed({1'b0, raw_ff}) - $signed({1'b0, MAP_LO});
   assign map_neg  = map_diff[RAW_W];
   assign map_mag  = map_neg ? RAW_W'(-map_diff) : RAW_W'(map_diff);
   assign map_num  = DIV_N_W'({map_mag, 8'b0}) - DIV_N_W'({map_mag, 1'b0});
   assign map_q    = $signed({2'b00, div_quot[VALUE_W-1:0]});
   assign map_sgn  = map_neg ? -map_q : map_q;
   assign map_full = map_sgn - 11'sd127;
   assign map_val  = (map_full >= -11'sd127 && map_full <= 11'sd127) ?
                     map_full[SAMPLE_W-1:0] : '0;

   assign v_abs = v_ff[SAMPLE_W-1] ? SAMPLE_W'(-v_ff) : SAMPLE_W'(v_ff);
   assign c_val = (v_abs > {1'b0, deadband}) ? v_ff : '0;
   assign t_val = 8'sd127 - $signed({1'b0, deadband});
   assign neg_t = -t_val;

   always_comb begin
      if (c_val <= neg_t) begin
         tri_res = SW_DOWN;
      end else if (c_val == '0) begin
         tri_res = SW_MID;
      end else if (c_val >= t_val) begin
         tri_res = SW_UP;
      end else begin
         tri_res = SW_DOWN;
      end
      if (c_val <= neg_t) begin
         dual_res = SW_DOWN;
      end else if (c_val >= t_val) begin
         dual_res = SW_ON;
      end else begin
         dual_res = SW_DOWN;
      end
   end

   // Slider: (v + 127) * 255 / 254.
   assign sld_sum = {v_ff[SAMPLE_W-1], v_ff} + 9'd127;
   assign sld_s   = sld_sum[SAMPLE_W-1:0];
   assign sld_num = DIV_N_W'({sld_s, 8'b0}) - DIV_N_W'(sld_s);

   assign acc_mag = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
   assign avg_q   = $signed({2'b00, div_quot[SAMPLE_W-2:0]});

   assign div_start = (state_ff == S_MAP_GO) || (state_ff == S_SLD_GO) ||
                      (state_ff == S_AVG_GO);

   always_comb begin
      case (state_ff)
         S_SLD_GO: begin
            div_dividend = sld_num;
            div_divisor  = SLIDER_SPAN;
         end
         S_AVG_GO: begin
            div_dividend = DIV_N_W'(acc_mag);
            div_divisor  = DIV_D_W'(win_fill);
         end
         default: begin
            div_dividend = map_num;
            div_divisor  = MAP_SPAN;
         end
      endcase
   end

   assign win_cmd.push = (state_ff == S_COND) && (kind == K_GYRO_X || kind == K_GYRO_Y);
   assign win_cmd.sel  = (kind == K_GYRO_Y);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = rsp_value_ff;

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      raw_in       = raw_ff;
      v_in         = v_ff;
      res_in       = res_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               chan_in  = req_chan.channel;
               raw_in   = req_chan.raw_value;
               state_in = S_MAP_GO;
            end
         end
         S_MAP_GO: begin
            state_in = S_MAP_WAIT;
         end
         S_MAP_WAIT: begin
            if (div_done) begin
               v_in     = map_val;
               state_in = S_COND;
            end
         end
         S_COND: begin
            case (kind)
               K_STICK: begin
                  res_in   = {c_val[SAMPLE_W-1], c_val};
                  state_in = S_DONE;
               end
               K_SLIDER: begin
                  state_in = S_SLD_GO;
               end
               K_TRI: begin
                  res_in   = tri_res;
                  state_in = S_DONE;
               end
               K_DUAL: begin
                  res_in   = dual_res;
                  state_in = S_DONE;
               end
               K_GYRO_X, K_GYRO_Y: begin
                  acc_in   = '0;
                  idx_in   = '0;
                  state_in = S_SUM;
               end
               default: begin
                  res_in   = '0;
                  state_in = S_DONE;
               end
            endcase
         end
         S_SLD_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_SUM: begin
            acc_in = acc_ff + SUM_W'(win_rd_data);
            idx_in = idx_ff + IDX_W'(1);
            if (FILL_W'(idx_ff) == win_fill - FILL_W'(1)) begin
               state_in = S_AVG_GO;
            end
         end
         S_AVG_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               if (kind == K_SLIDER) begin
                  res_in = $signed({1'b0, div_quot[SAMPLE_W-1:0]});
               end else begin
                  res_in = acc_ff[SUM_W-1] ? -avg_q : avg_q;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chan_ff      <= chan_in;
      raw_ff       <= raw_in;
      v_ff         <= v_in;
      res_ff       <= res_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
   end

`ifndef ASSERT_OFF
   a_accept_starts_map: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == S_MAP_GO))
      else $error("accepted item did not start the mapping division");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result item raised outside the completion state");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_MAP_WAIT || state_ff == S_DIV_WAIT))
      else $error("divider finished while the sequencer was not waiting");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      win_fill <= FILL_W'(WINDOW_DEPTH))
      else $error("gyro window fill count exceeds its depth");
`endif

endmodule

/* hdl/rcc_csr.sv */
// ----------------------------------------------------------------------------
// rcc_csr: configuration register block
// APB-style access to the deadband register.
// ----------------------------------------------------------------------------
module rcc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rcc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rcc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rcc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [rcc_pkg::DB_W-1:0]        deadband
);
   import rcc_pkg::*;

   localparam logic REG_DEADBAND = 1'b0;

   logic [DB_W-1:0] deadband_ff;
   logic            reg_index;
   logic            wr_en;

   assign reg_index = paddr[CSR_ADDR_W-1];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign deadband  = deadband_ff;
   assign prdata    = (reg_index == REG_DEADBAND) ? CSR_DATA_W'(deadband_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RESET;
      end else if (wr_en && reg_index == REG_DEADBAND) begin
         deadband_ff <= pwdata[DB_W-1:0];
      end
   end

endmodule

/* hdl/rcc_divider.sv */
// ----------------------------------------------------------------------------
// rcc_divider: shared iterative divider
// Unsigned restoring division, a few quotient bits per clock cycle.
// ----------------------------------------------------------------------------
module rcc_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rcc_pkg::DIV_N_W-1:0]  dividend,
   input  logic [rcc_pkg::DIV_D_W-1:0]  divisor,
   output logic                         done,
   output logic [rcc_pkg::DIV_N_W-1:0]  quotient
);
   import rcc_pkg::*;

   localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DIV_N_W-1:0] num_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_D_W-1:0] den_ff;
   logic [DIV_N_W-1:0] step_num;
   logic [DIV_D_W-1:0] step_rem;

   always_comb begin
      logic [DIV_D_W:0] trial;
      step_num = num_ff;
      step_rem = rem_ff;
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
         trial    = {step_rem, step_num[DIV_N_W-1]};
         step_num = {step_num[DIV_N_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            step_rem    = DIV_D_W'(trial - {1'b0, den_ff});
            step_num[0] = 1'b1;
         end else begin
            step_rem = trial[DIV_D_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= step_num;
         rem_ff <= step_rem;
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

/* hdl/rcc_window.sv */
// ----------------------------------------------------------------------------
// rcc_window: gyro sample windows
// Two sample shift lines with saturating fill counts and one read port.
// ----------------------------------------------------------------------------
module rcc_window #(
   parameter int WINDOW_DEPTH = rcc_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
   parameter int FILL_W       = $clog2(WINDOW_DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rcc_pkg::win_cmd_type                cmd,
   input  logic signed [rcc_pkg::SAMPLE_W-1:0] sample,
   input  logic [IDX_W-1:0]                    rd_idx,
   output logic signed [rcc_pkg::SAMPLE_W-1:0] rd_data,
   output logic [FILL_W-1:0]                   fill
);
   import rcc_pkg::*;

   logic signed [SAMPLE_W-1:0] win_ff [2][WINDOW_DEPTH];
   logic [FILL_W-1:0]          fill_ff [2];

   for (genvar r = 0; r < 2; r++) begin : g_row
      always_ff @(posedge clock) begin
         if (cmd.push && cmd.sel == 1'(r)) begin
            win_ff[r][0] <= sample;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
               win_ff[r][i] <= win_ff[r][i-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            fill_ff[r] <= '0;
         end else if (cmd.push && cmd.sel == 1'(r) &&
                      fill_ff[r] != FILL_W'(WINDOW_DEPTH)) begin
            fill_ff[r] <= fill_ff[r] + FILL_W'(1);
         end
      end
   end

   assign rd_data = win_ff[cmd.sel][rd_idx];
   assign fill    = fill_ff[cmd.sel];

endmodule
